[sv/purp_pkg.sv]
// ----------------------------------------------------------------------------
// purp_pkg
// Shared types, codes and helpers of the picture unit register port: request
// and response payloads, controller/datapath links and video address folding.
// ----------------------------------------------------------------------------
package purp_pkg;

    // Memory geometry.
    localparam int VIDEO_AW     = 14;
    localparam int SPRITE_AW    = 8;
    localparam int VIDEO_DEPTH  = 1 << VIDEO_AW;
    localparam int SPRITE_DEPTH = 1 << SPRITE_AW;

    // Configuration port geometry.
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;
    localparam logic [CFG_AW-1:0] CFG_ADDR_ENABLE = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_ADDR_MIRROR = 3'd4;

    // Request command codes.
    localparam logic [1:0] CMD_READ   = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_VBLANK = 2'd2;
    localparam logic [1:0] CMD_FRAME  = 2'd3;

    // Register window indexes.
    localparam logic [2:0] REG_CTRL      = 3'd0;
    localparam logic [2:0] REG_MASK      = 3'd1;
    localparam logic [2:0] REG_STATUS    = 3'd2;
    localparam logic [2:0] REG_OAM_ADDR  = 3'd3;
    localparam logic [2:0] REG_OAM_DATA  = 3'd4;
    localparam logic [2:0] REG_SCROLL    = 3'd5;
    localparam logic [2:0] REG_ADDR      = 3'd6;
    localparam logic [2:0] REG_DATA      = 3'd7;

    // Register constants.
    localparam logic [7:0]          STATUS_RESET   = 8'hA0;
    localparam logic [7:0]          READ_UNMAPPED  = 8'hFF;
    localparam logic [VIDEO_AW-1:0] NT_MIRROR_OFF  = 14'h0400;
    localparam logic [VIDEO_AW-1:0] INC_ROW        = 14'd32;
    localparam logic [VIDEO_AW-1:0] INC_ONE        = 14'd1;
    localparam logic [5:0]          PALETTE_PAGE   = 6'h3F;

    // Request payload.
    typedef struct packed {
        logic [1:0] cmd;
        logic [2:0] reg_index;
        logic [7:0] write_data;
    } t_purp_req;

    // Response payload.
    typedef struct packed {
        logic [7:0] read_data;
        logic       nmi_enable;
        logic       in_vblank;
    } t_purp_rsp;

    // Controller commands to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
        logic mirror_wr;
    } t_purp_ctl;

    // Datapath status to the controller.
    typedef struct packed {
        logic mirror_needed;
    } t_purp_sts;

    // Configuration values.
    typedef struct packed {
        logic writes_enabled;
        logic mirroring;
    } t_purp_cfg;

    // Fold palette addresses into 32 entries; sprite backdrop entries alias
    // the background backdrop entries.
    function automatic logic [VIDEO_AW-1:0] purp_map_addr(input logic [VIDEO_AW-1:0] a);
        logic [VIDEO_AW-1:0] m;
        m = a;
        if (a[13:8] == PALETTE_PAGE) begin
            m = {PALETTE_PAGE, 3'b000, a[4] & (a[1:0] != 2'b00), a[3:0]};
        end
        return m;
    endfunction

endpackage

[sv/purp_ctrl.sv]
// ----------------------------------------------------------------------------
// purp_ctrl
// Sequencer of the register port: accepts one request, runs the execute
// step, adds a second memory write step for mirrored nametable writes, and
// holds the response valid until it is taken.
// ----------------------------------------------------------------------------
module purp_ctrl
    import purp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    input  t_purp_sts i_sts,
    output t_purp_ctl o_ctl
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MIRROR
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_capture;

    // A request is taken only when the response slot is free or draining.
    assign o_in_ready  = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign w_capture   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    // Commands decoded from the current state.
    always_comb begin
        o_ctl.capture   = w_capture;
        o_ctl.execute   = (r_state == ST_EXEC);
        o_ctl.mirror_wr = (r_state == ST_MIRROR);
    end

    // State and response valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (r_out_valid && i_out_ready) begin
                        r_out_valid <= 1'b0;
                    end
                    if (w_capture) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_out_valid <= 1'b1;
                    if (i_sts.mirror_needed) begin
                        r_state <= ST_MIRROR;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_MIRROR: begin
                    if (r_out_valid && i_out_ready) begin
                        r_out_valid <= 1'b0;
                    end
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // A captured request is executed in the next cycle.
    a_capture_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_capture |=> (r_state == ST_EXEC))
        else $error("captured request not executed");

    // Execution always produces a pending response.
    a_exec_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |=> r_out_valid)
        else $error("execute step left no response");

    // The mirror write only follows an execute step.
    a_mirror_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MIRROR) |-> ($past(r_state) == ST_EXEC))
        else $error("mirror write without execute step");

    // No new request while a response would be overwritten.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |-> (!r_out_valid || $past(i_out_ready)))
        else $error("response overrun");

endmodule

[sv/purp_datapath.sv]
// ----------------------------------------------------------------------------
// purp_datapath
// Register file, video memory and sprite memory of the register port. The
// memories are read every cycle at the current addresses so read data is
// ready in the execute step; writes happen in the execute and mirror steps.
// ----------------------------------------------------------------------------
module purp_datapath
    import purp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_purp_ctl i_ctl,
    input  t_purp_cfg i_cfg,
    input  t_purp_req i_req,
    output t_purp_sts o_sts,
    output t_purp_rsp o_rsp
);

    // Architectural registers.
    logic [7:0]          r_ctrl,       n_ctrl;
    logic [7:0]          r_mask,       n_mask;
    logic [7:0]          r_status,     n_status;
    logic [7:0]          r_oam_addr,   n_oam_addr;
    logic [7:0]          r_scroll_x,   n_scroll_x;
    logic [7:0]          r_scroll_y,   n_scroll_y;
    logic [VIDEO_AW-1:0] r_vaddr,      n_vaddr;
    logic [7:0]          r_hi_latch,   n_hi_latch;
    logic                r_scroll_tog, n_scroll_tog;
    logic                r_addr_tog,   n_addr_tog;
    logic                r_first_read, n_first_read;

    // Request, memory read data, mirror target and response.
    t_purp_req           r_req;
    logic [7:0]          r_vdout;
    logic [7:0]          r_sdout;
    logic [VIDEO_AW-1:0] r_mirror_addr, n_mirror_addr;
    t_purp_rsp           r_rsp,         n_rsp;

    // Memories.
    logic [7:0] r_vmem [VIDEO_DEPTH];
    logic [7:0] r_smem [SPRITE_DEPTH];

    logic [VIDEO_AW-1:0] w_vaddr_map;
    logic [VIDEO_AW-1:0] w_vaddr_inc;
    logic [VIDEO_AW-1:0] w_mirror_off;
    logic                w_is_write;
    logic                w_vmem_we;
    logic [VIDEO_AW-1:0] w_vmem_waddr;
    logic                w_smem_we;
    logic [7:0]          w_rd;

    // Address helpers.
    assign w_vaddr_map  = purp_map_addr(r_vaddr);
    assign w_vaddr_inc  = r_vaddr + (r_ctrl[2] ? INC_ROW : INC_ONE);
    assign w_mirror_off = i_cfg.mirroring ? (NT_MIRROR_OFF << 1) : NT_MIRROR_OFF;
    assign w_is_write   = (r_req.cmd == CMD_WRITE);

    // Data writes above the pattern area also need the mirror copy.
    assign o_sts.mirror_needed = w_is_write && (r_req.reg_index == REG_DATA) && r_vaddr[13];

    // Memory write ports.
    assign w_vmem_we    = (i_ctl.execute && w_is_write && (r_req.reg_index == REG_DATA))
                          || i_ctl.mirror_wr;
    assign w_vmem_waddr = i_ctl.mirror_wr ? r_mirror_addr : w_vaddr_map;
    assign w_smem_we    = i_ctl.execute && w_is_write && (r_req.reg_index == REG_OAM_DATA);

    // Register updates for one request.
    always_comb begin
        n_ctrl        = r_ctrl;
        n_mask        = r_mask;
        n_status      = r_status;
        n_oam_addr    = r_oam_addr;
        n_scroll_x    = r_scroll_x;
        n_scroll_y    = r_scroll_y;
        n_vaddr       = r_vaddr;
        n_hi_latch    = r_hi_latch;
        n_scroll_tog  = r_scroll_tog;
        n_addr_tog    = r_addr_tog;
        n_first_read  = r_first_read;
        n_mirror_addr = purp_map_addr(r_vaddr ^ w_mirror_off);
        w_rd          = 8'h00;
        if (i_ctl.execute) begin
            case (r_req.cmd)
                CMD_READ: begin
                    case (r_req.reg_index)
                        REG_STATUS: begin
                            w_rd         = r_status;
                            n_status[7]  = 1'b0;
                            n_scroll_tog = 1'b0;
                            n_addr_tog   = 1'b0;
                            n_first_read = 1'b1;
                        end
                        REG_OAM_DATA: begin
                            w_rd = r_sdout;
                        end
                        REG_DATA: begin
                            w_rd = r_vdout;
                            if (r_first_read) begin
                                n_first_read = 1'b0;
                            end else begin
                                n_vaddr = w_vaddr_inc;
                            end
                        end
                        default: begin
                            w_rd = READ_UNMAPPED;
                        end
                    endcase
                end
                CMD_WRITE: begin
                    case (r_req.reg_index)
                        REG_CTRL: begin
                            if (i_cfg.writes_enabled) begin
                                n_ctrl = r_req.write_data;
                            end
                        end
                        REG_MASK: begin
                            if (i_cfg.writes_enabled) begin
                                n_mask = r_req.write_data;
                            end
                        end
                        REG_OAM_ADDR: begin
                            n_oam_addr = r_req.write_data;
                        end
                        REG_OAM_DATA: begin
                            n_oam_addr = r_oam_addr + 8'd1;
                        end
                        REG_SCROLL: begin
                            if (r_scroll_tog) begin
                                n_scroll_y = r_req.write_data;
                            end else begin
                                n_scroll_x = r_req.write_data;
                            end
                            n_scroll_tog = !r_scroll_tog;
                        end
                        REG_ADDR: begin
                            if (i_cfg.writes_enabled) begin
                                if (r_addr_tog) begin
                                    n_vaddr = {r_hi_latch[5:0], r_req.write_data};
                                end else begin
                                    n_hi_latch = r_req.write_data;
                                end
                                n_addr_tog   = !r_addr_tog;
                                n_first_read = 1'b1;
                            end
                        end
                        REG_DATA: begin
                            n_vaddr = w_vaddr_inc;
                        end
                        default: begin
                        end
                    endcase
                end
                CMD_VBLANK: begin
                    n_status[7] = 1'b1;
                end
                default: begin
                    n_status[7:5] = 3'b000;
                end
            endcase
        end
        n_rsp.read_data  = w_rd;
        n_rsp.nmi_enable = n_ctrl[7];
        n_rsp.in_vblank  = n_status[7];
    end

    // Control state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl       <= 8'h00;
            r_mask       <= 8'h00;
            r_status     <= STATUS_RESET;
            r_oam_addr   <= 8'h00;
            r_scroll_x   <= 8'h00;
            r_scroll_y   <= 8'h00;
            r_vaddr      <= '0;
            r_hi_latch   <= 8'h00;
            r_scroll_tog <= 1'b0;
            r_addr_tog   <= 1'b0;
            r_first_read <= 1'b1;
        end else begin
            r_ctrl       <= n_ctrl;
            r_mask       <= n_mask;
            r_status     <= n_status;
            r_oam_addr   <= n_oam_addr;
            r_scroll_x   <= n_scroll_x;
            r_scroll_y   <= n_scroll_y;
            r_vaddr      <= n_vaddr;
            r_hi_latch   <= n_hi_latch;
            r_scroll_tog <= n_scroll_tog;
            r_addr_tog   <= n_addr_tog;
            r_first_read <= n_first_read;
        end
    end

    // Payload registers: request, mirror target and response.
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_req <= i_req;
        end
        if (i_ctl.execute) begin
            r_mirror_addr <= n_mirror_addr;
            r_rsp         <= n_rsp;
        end
    end

    // Video memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_vmem_we) begin
            r_vmem[w_vmem_waddr] <= r_req.write_data;
        end
        r_vdout <= r_vmem[w_vaddr_map];
    end

    // Sprite memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_smem_we) begin
            r_smem[r_oam_addr] <= r_req.write_data;
        end
        r_sdout <= r_smem[r_oam_addr];
    end

    assign o_rsp = r_rsp;

    // Both video write steps never fall in the same cycle.
    a_one_vwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctl.execute && i_ctl.mirror_wr))
        else $error("execute and mirror write overlap");

    // The mirror copy never lands on the primary address.
    a_mirror_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.execute && o_sts.mirror_needed) |=> (r_mirror_addr != purp_map_addr($past(r_vaddr))))
        else $error("mirror copy hits primary address");

    // Registers hold while no request executes.
    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctl.execute |=> ($stable(r_vaddr) && $stable(r_status) && $stable(r_ctrl)))
        else $error("register changed without a request");

endmodule

[sv/picture_unit_register_port.sv]
// ----------------------------------------------------------------------------
// picture_unit_register_port
// CPU-facing register window of a tile picture unit: request sequencer,
// register and memory datapath, and the APB configuration registers.
// ----------------------------------------------------------------------------
// Sequence: accepted, executed in the next cycle, response valid the cycle after;
//   a data write at 0x2000 or above adds a mirrored nametable write step.
// Requests: one at a time; the next is taken after the execute step on registered
//   memory read data and any mirror write; a waiting response holds off input.
// Reset: synchronous, active low; control registers take their reset values.
//   Payload registers and the video and sprite memories are not cleared.
module picture_unit_register_port
    import purp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_purp_req         i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_purp_rsp         o_out_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    logic      r_writes_enabled;
    logic      r_mirroring;
    logic      w_cfg_wr;
    t_purp_cfg w_cfg;
    t_purp_ctl w_ctl;
    t_purp_sts w_sts;

    // Configuration write strobe.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_writes_enabled <= 1'b0;
            r_mirroring      <= 1'b0;
        end else if (w_cfg_wr) begin
            if (paddr == CFG_ADDR_ENABLE) begin
                r_writes_enabled <= pwdata[0];
            end
            if (paddr == CFG_ADDR_MIRROR) begin
                r_mirroring <= pwdata[0];
            end
        end
    end

    // Configuration read back.
    always_comb begin
        prdata = '0;
        case (paddr)
            CFG_ADDR_ENABLE: prdata[0] = r_writes_enabled;
            CFG_ADDR_MIRROR: prdata[0] = r_mirroring;
            default:         prdata    = '0;
        endcase
    end

    assign w_cfg.writes_enabled = r_writes_enabled;
    assign w_cfg.mirroring      = r_mirroring;

    // Request sequencer.
    purp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_ctl       (w_ctl)
    );

    // Registers and memories.
    purp_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_cfg   (w_cfg),
        .i_req   (i_in_req),
        .o_sts   (w_sts),
        .o_rsp   (o_out_rsp)
    );

endmodule
